@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ rtl/rv32_pkg.sv @@
// ----------------------------------------------------------------------------
// rv32_pkg
// types and constants of the execute unit
// ----------------------------------------------------------------------------
`default_nettype none
package rv32_pkg;
   localparam int unsigned CsrEntries = 4096;
   localparam int unsigned RegCount   = 32;

   typedef enum logic [1:0] {
      KIND_RETIRE  = 2'd0,
      KIND_READ    = 2'd1,
      KIND_WRITE   = 2'd2,
      KIND_ILLEGAL = 2'd3
   } kind_type;

   localparam logic [4:0] OP_LOAD   = 5'h00;
   localparam logic [4:0] OP_IMM    = 5'h04;
   localparam logic [4:0] OP_AUIPC  = 5'h05;
   localparam logic [4:0] OP_STORE  = 5'h08;
   localparam logic [4:0] OP_REG    = 5'h0C;
   localparam logic [4:0] OP_LUI    = 5'h0D;
   localparam logic [4:0] OP_BRANCH = 5'h18;
   localparam logic [4:0] OP_JALR   = 5'h19;
   localparam logic [4:0] OP_JAL    = 5'h1B;
   localparam logic [4:0] OP_SYSTEM = 5'h1C;

   localparam logic [6:0] F7_ALT = 7'h20;

   typedef struct packed {
      logic        operation;
      logic [31:0] instruction;
      logic [31:0] load_word;
   } req_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [31:0] next_pc;
      logic [31:0] mem_address;
      logic [31:0] mem_write_data;
      logic [3:0]  byte_enable;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
   } rsp_type;
endpackage
`default_nettype wire

@@ rtl/rv32_req_if.sv @@
// ----------------------------------------------------------------------------
// rv32_req_if
// request channel interface
// ----------------------------------------------------------------------------
`default_nettype none
interface rv32_req_if import rv32_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/rv32_rsp_if.sv @@
// ----------------------------------------------------------------------------
// rv32_rsp_if
// response channel interface
// ----------------------------------------------------------------------------
`default_nettype none
interface rv32_rsp_if import rv32_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/rv32i_execute_unit.sv @@
// ----------------------------------------------------------------------------
// rv32i_execute_unit
// rv32i + zicsr execute unit with register file and csr store in memories
// ----------------------------------------------------------------------------
// Each item takes two stages. At acceptance the register file and csr memory
// are read (synchronous). Once the item is in stage 1 and the output can take
// it, the item is executed, its result is registered on the output and its
// writes go back. Register and csr writes of the executing item are forwarded
// to the item accepted in the same cycle, so one item is accepted every cycle
// while the output can take it. A held result stalls the input. After reset a
// clear pass over max(CSR_ENTRIES, REG_COUNT) entries zeroes the register file
// and the csr store, and no item is accepted during it. Reset also returns the
// reset pc register to zero, and while reset is held the pc is loaded from it.
`default_nettype none
`include "assert_macros.svh"
module rv32i_execute_unit import rv32_pkg::*; #(
   parameter int unsigned CSR_ENTRIES = CsrEntries,
   parameter int unsigned REG_COUNT   = RegCount
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data,
   rv32_req_if.sink         req,
   rv32_rsp_if.source       rsp
);
   localparam int unsigned CW = (CSR_ENTRIES > 1) ? $clog2(CSR_ENTRIES) : 1;
   localparam int unsigned RW = $clog2(REG_COUNT);
   localparam int unsigned CLR_N = (CSR_ENTRIES > REG_COUNT) ? CSR_ENTRIES : REG_COUNT;
   localparam int unsigned NW = $clog2(CLR_N);

   logic [31:0] reset_pc_ff;
   logic [31:0] regs [REG_COUNT];
   logic [31:0] csrs [CSR_ENTRIES];

   // clear pass
   logic          clr_ff;
   logic [NW:0]   clr_cnt_ff;

   // stage 1 (memory read latency) and output
   logic          s1_valid_ff;
   req_type       s1_ff;
   logic [31:0]   ra_ff, rb_ff, rc_ff;
   logic          out_valid_ff;
   rsp_type       out_ff;

   logic [31:0]   pc_ff;
   logic          pend_ff;
   logic [4:0]    pend_rd_ff;
   logic [2:0]    pend_f3_ff;
   logic [1:0]    pend_off_ff;

   logic          adv;
   assign adv = !out_valid_ff || rsp.ready;
   assign req.ready = !clr_ff && adv;
   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;

   wire logic       acc = req.valid && req.ready;
   wire logic [31:0] ii = req.payload.instruction;

   // execute of stage 1 item
   logic [31:0] ins, a, b, csr_old, pc;
   logic [4:0]  rd, rs1, rs2, opc;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] immi, v, t, ea, tmp;
   logic        take, cwe;
   logic [31:0] cwv;
   logic [11:0] caddr;
   rsp_type     r;
   logic        np_en, np_set;

   // forwarding of the writes made this cycle to the item being read
   logic        fwd_ra, fwd_rb, fwd_c;

   function automatic logic [31:0] alu(input logic [2:0] fn, input logic alt,
                                       input logic [31:0] x, input logic [31:0] y);
      logic [31:0] res;
      case (fn)
         3'd0:    res = alt ? x - y : x + y;
         3'd1:    res = x << y[4:0];
         3'd2:    res = {31'd0, $signed(x) < $signed(y)};
         3'd3:    res = {31'd0, x < y};
         3'd4:    res = x ^ y;
         3'd5:    res = alt ? 32'($signed(x) >>> y[4:0]) : x >> y[4:0];
         3'd6:    res = x | y;
         default: res = x & y;
      endcase
      return res;
   endfunction

   always_comb begin
      ins = s1_ff.instruction;
      rd = ins[11:7]; f3 = ins[14:12]; rs1 = ins[19:15]; rs2 = ins[24:20];
      f7 = ins[31:25]; opc = ins[6:2]; caddr = ins[31:20];
      a = ra_ff; b = rb_ff; csr_old = rc_ff; pc = pc_ff;
      immi = {{20{ins[31]}}, ins[31:20]};
      r = '0; r.result_kind = KIND_ILLEGAL; r.next_pc = pc;
      v = '0; t = '0; ea = '0; tmp = '0; take = 1'b0;
      cwe = 1'b0; cwv = '0; np_en = 1'b0; np_set = 1'b0;
      if (s1_ff.operation) begin
         r.result_kind = KIND_RETIRE;
         if (pend_ff) begin
            np_en = 1'b1;
            t = s1_ff.load_word >> {pend_off_ff, 3'b000};
            case (pend_f3_ff)
               3'd0:    v = {{24{t[7]}}, t[7:0]};
               3'd1:    v = {{16{t[15]}}, t[15:0]};
               3'd4:    v = {24'd0, t[7:0]};
               3'd5:    v = {16'd0, t[15:0]};
               default: v = s1_ff.load_word;
            endcase
            r.dest_index = pend_rd_ff;
            r.dest_value = (pend_rd_ff != 5'd0) ? v : 32'd0;
         end
      end else begin
         np_en = 1'b1;
         if (ins[1:0] == 2'b11) begin
            unique case (opc)
               OP_LUI: begin
                  r.result_kind = KIND_RETIRE; r.next_pc = pc + 32'd4;
                  r.dest_index = rd; r.dest_value = {ins[31:12], 12'd0};
               end
               OP_AUIPC: begin
                  r.result_kind = KIND_RETIRE; r.next_pc = pc + 32'd4;
                  r.dest_index = rd; r.dest_value = pc + {ins[31:12], 12'd0};
               end
               OP_JAL: begin
                  r.result_kind = KIND_RETIRE;
                  r.next_pc = pc + {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
                  r.dest_index = rd; r.dest_value = pc + 32'd4;
               end
               OP_JALR: if (f3 == 3'd0) begin
                  r.result_kind = KIND_RETIRE;
                  tmp = a + immi;
                  r.next_pc = {tmp[31:1], 1'b0};
                  r.dest_index = rd; r.dest_value = pc + 32'd4;
               end
               OP_BRANCH: if (f3 != 3'd2 && f3 != 3'd3) begin
                  case (f3)
                     3'd0:    take = a == b;
                     3'd1:    take = a != b;
                     3'd4:    take = $signed(a) < $signed(b);
                     3'd5:    take = !($signed(a) < $signed(b));
                     3'd6:    take = a < b;
                     default: take = a >= b;
                  endcase
                  r.result_kind = KIND_RETIRE;
                  r.next_pc = take ? pc + {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0}
                                   : pc + 32'd4;
               end
               OP_LOAD: if (f3 != 3'd3 && f3 < 3'd6) begin
                  ea = a + immi;
                  np_set = 1'b1;
                  r.result_kind = KIND_READ; r.next_pc = pc + 32'd4;
                  r.mem_address = ea;
               end
               OP_STORE: if (f3 <= 3'd2) begin
                  ea = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
                  r.result_kind = KIND_WRITE; r.next_pc = pc + 32'd4;
                  r.mem_address = ea;
                  r.mem_write_data = b << {ea[1:0], 3'b000};
                  r.byte_enable = 4'((f3 == 3'd0 ? 4'h1 : f3 == 3'd1 ? 4'h3 : 4'hf)
                                     << ea[1:0]);
               end
               OP_IMM: begin
                  if (f3 == 3'd1) begin
                     if (f7 == 7'd0) begin
                        r.result_kind = KIND_RETIRE;
                        v = alu(3'd1, 1'b0, a, {27'd0, rs2});
                     end
                  end else if (f3 == 3'd5) begin
                     if (f7 == 7'd0 || f7 == F7_ALT) begin
                        r.result_kind = KIND_RETIRE;
                        v = alu(3'd5, f7 == F7_ALT, a, {27'd0, rs2});
                     end
                  end else begin
                     r.result_kind = KIND_RETIRE;
                     v = alu(f3, 1'b0, a, immi);
                  end
                  if (r.result_kind == KIND_RETIRE) begin
                     r.next_pc = pc + 32'd4; r.dest_index = rd; r.dest_value = v;
                  end
               end
               OP_REG: if (f7 == 7'd0 || (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
                  r.result_kind = KIND_RETIRE; r.next_pc = pc + 32'd4;
                  r.dest_index = rd; r.dest_value = alu(f3, f7 == F7_ALT, a, b);
               end
               OP_SYSTEM: if (f3 != 3'd0 && f3 != 3'd4) begin
                  t = f3[2] ? {27'd0, rs1} : a;
                  case (f3[1:0])
                     2'd1:    cwv = t;
                     2'd2:    cwv = csr_old | t;
                     default: cwv = csr_old & ~t;
                  endcase
                  cwe = 32'(caddr) < CSR_ENTRIES;
                  r.result_kind = KIND_RETIRE; r.next_pc = pc + 32'd4;
                  r.dest_index = rd; r.dest_value = csr_old;
               end
               default: ;
            endcase
         end
         if (r.dest_index == 5'd0) r.dest_value = '0;
      end
   end

   wire logic fire = s1_valid_ff && adv;
   wire logic rwe  = fire && r.dest_index != 5'd0;
   wire logic cmw  = fire && cwe;

   assign fwd_ra = rwe && r.dest_index == ii[19:15];
   assign fwd_rb = rwe && r.dest_index == ii[24:20];
   assign fwd_c  = cmw && caddr == ii[31:20];

   logic [31:0] rdA, rdB, rdC;
   logic        bypA, bypB, bypC;
   logic [31:0] bvA, bvB, bvC;

   always_ff @(posedge clock) begin
      // register file with clear pass
      if (clr_ff) begin
         if (32'(clr_cnt_ff) < REG_COUNT) regs[clr_cnt_ff[RW-1:0]] <= '0;
      end else if (rwe) begin
         regs[r.dest_index[RW-1:0]] <= r.dest_value;
      end
      if (acc) begin
         rdA <= regs[ii[15+RW-1:15]];
         rdB <= regs[ii[20+RW-1:20]];
      end
      // csr memory with clear pass
      if (clr_ff) begin
         if (32'(clr_cnt_ff) < CSR_ENTRIES) csrs[clr_cnt_ff[CW-1:0]] <= '0;
      end else if (cmw) begin
         csrs[caddr[CW-1:0]] <= cwv;
      end
      if (acc) rdC <= csrs[ii[20+CW-1:20]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1; clr_cnt_ff <= '0;
         s1_valid_ff <= 1'b0; out_valid_ff <= 1'b0;
         pc_ff <= reset_pc_ff; pend_ff <= 1'b0;
         pend_rd_ff <= '0; pend_f3_ff <= '0; pend_off_ff <= '0;
      end else begin
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == (NW+1)'(CLR_N - 1)) clr_ff <= 1'b0;
         end
         if (adv) begin
            out_valid_ff <= s1_valid_ff;
            s1_valid_ff <= acc;
         end
         if (fire) begin
            out_ff <= r;
            pc_ff <= r.next_pc;
            if (np_en) pend_ff <= np_set;
            if (np_set) begin
               pend_rd_ff <= rd; pend_f3_ff <= f3; pend_off_ff <= ea[1:0];
            end
         end
      end
      if (acc) begin
         s1_ff <= req.payload;
         bypA <= fwd_ra || ii[19:15] == 5'd0 || 32'(ii[19:15]) >= REG_COUNT;
         bvA  <= fwd_ra ? r.dest_value : '0;
         bypB <= fwd_rb || ii[24:20] == 5'd0 || 32'(ii[24:20]) >= REG_COUNT;
         bvB  <= fwd_rb ? r.dest_value : '0;
         bypC <= fwd_c || 32'(ii[31:20]) >= CSR_ENTRIES;
         bvC  <= fwd_c ? cwv : '0;
      end
   end

   assign ra_ff = bypA ? bvA : rdA;
   assign rb_ff = bypB ? bvB : rdB;
   assign rc_ff = bypC ? bvC : rdC;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_pc_ff <= '0;
      end else if (csr_write_enable) begin
         reset_pc_ff <= csr_write_data;
      end
   end

   `ASSERT_NEVER(a_no_accept_clr, clock, reset, clr_ff && req.valid && req.ready)
   `ASSERT_IMPL(a_x0_zero, clock, reset,
      (rsp.valid && rsp.payload.dest_index == 5'd0) |-> rsp.payload.dest_value == 32'd0)
   `ASSERT_IMPL(a_illegal_pc, clock, reset,
      (fire && r.result_kind == KIND_ILLEGAL) |=> pc_ff == $past(pc_ff))
   `ASSERT_NEVER(a_be_only_store, clock, reset,
      rsp.valid && rsp.payload.result_kind != KIND_WRITE && rsp.payload.byte_enable != 4'd0)
endmodule
`default_nettype wire
